### design/sawh_pkg.sv
package sawh_pkg;

    localparam int ARENA_BYTES  = 4096;
    localparam int HEADER_BYTES = 8;
    localparam int ADDR_W       = $clog2(ARENA_BYTES);
    localparam int OFS_W        = 13;
    localparam int ALIGN_W      = 4;
    localparam int ADJ_W        = 12;
    localparam int ENTRY_W      = ADJ_W + OFS_W;

    typedef enum logic [1:0] {
        OP_ALLOC    = 2'd0,
        OP_FREE     = 2'd1,
        OP_ROLLBACK = 2'd2,
        OP_RESET    = 2'd3
    } t_opcode;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_NO_SPACE   = 3'd1,
        ST_NULL       = 3'd2,
        ST_BAD_HEADER = 3'd3,
        ST_NOT_TOP    = 3'd4,
        ST_BAD_MARKER = 3'd5
    } t_status;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [OFS_W-1:0]   request_bytes;
        logic [ALIGN_W-1:0] align_log2;
        logic [OFS_W-1:0]   free_offset;
        logic [OFS_W-1:0]   marker_offset;
    } t_req_item;

    typedef struct packed {
        logic [2:0]         status;
        logic [OFS_W-1:0]   granted_offset;
        logic [OFS_W-1:0]   granted_bytes;
        logic [ALIGN_W-1:0] granted_align_log2;
        logic [OFS_W-1:0]   used_bytes;
        logic [OFS_W-1:0]   peak_bytes;
    } t_rsp_item;

    typedef struct packed {
        logic clear;
        logic capture;
        logic commit;
    } t_ctrl_cmd;

    typedef struct packed {
        logic clr_done;
    } t_ctrl_sts;

endpackage

### design/sawh_if.sv
interface sawh_req_if;
    logic                 valid;
    logic                 ready;
    sawh_pkg::t_req_item  payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface sawh_rsp_if;
    logic                 valid;
    logic                 ready;
    sawh_pkg::t_rsp_item  payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface sawh_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [sawh_pkg::OFS_W-1:0]    data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### design/stack_allocator_with_headers.sv
// The header store is read and the request registered at the accepting edge; then
// compare and update run, and the result enters the output register once that
// register is empty or emptying. The next transaction is accepted only after the
// result has entered it, even while that result still waits to be taken.
// After reset the header store is cleared one entry a cycle, all 4096 entries,
// before the first request is accepted; configuration writes are taken always.
module stack_allocator_with_headers (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sawh_cfg_if.sink    i_cfg,
    sawh_req_if.sink    i_req,
    sawh_rsp_if.source  o_rsp
);
    import sawh_pkg::*;

    t_ctrl_cmd cmd;
    t_ctrl_sts sts;

    assign i_cfg.ready = 1'b1;

    sawh_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .o_rsp_valid (o_rsp.valid),
        .i_rsp_ready (o_rsp.ready),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    sawh_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .i_req      (i_req.payload),
        .i_cfg_we   (i_cfg.valid),
        .i_cfg_data (i_cfg.data),
        .o_rsp      (o_rsp.payload)
    );

endmodule

### design/sawh_ctrl.sv
module sawh_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_req_valid,
    output logic                 o_req_ready,
    output logic                 o_rsp_valid,
    input  logic                 i_rsp_ready,
    output sawh_pkg::t_ctrl_cmd  o_cmd,
    input  sawh_pkg::t_ctrl_sts  i_sts
);
    import sawh_pkg::*;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC
    } t_state;

    t_state r_state, n_state;
    logic   r_in_ready;
    logic   r_out_valid;
    logic   accept;
    logic   commit;

    assign accept = r_in_ready & i_req_valid;
    // The result is written only when the output register is empty or emptying.
    assign commit = (r_state == S_EXEC) && (!r_out_valid || i_rsp_ready);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (i_sts.clr_done) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (accept) n_state = S_EXEC;
            end
            S_EXEC: begin
                if (commit) n_state = S_IDLE;
            end
            default: n_state = S_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_in_ready  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_in_ready <= (n_state == S_IDLE);
            if (commit) begin
                r_out_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_req_ready   = r_in_ready;
    assign o_rsp_valid   = r_out_valid;
    assign o_cmd.clear   = (r_state == S_CLEAR);
    assign o_cmd.capture = accept;
    assign o_cmd.commit  = commit;

endmodule

### design/sawh_dp.sv
module sawh_dp (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  sawh_pkg::t_ctrl_cmd          i_cmd,
    output sawh_pkg::t_ctrl_sts          o_sts,
    input  sawh_pkg::t_req_item          i_req,
    input  logic                         i_cfg_we,
    input  logic [sawh_pkg::OFS_W-1:0]   i_cfg_data,
    output sawh_pkg::t_rsp_item          o_rsp
);
    import sawh_pkg::*;

    localparam int SUM_W = OFS_W + 4;
    localparam int END_W = SUM_W + 1;

    logic [ENTRY_W-1:0] mem [ARENA_BYTES];

    logic [OFS_W-1:0]   r_arena;
    logic [OFS_W-1:0]   r_top, n_top;
    logic [OFS_W-1:0]   r_peak, n_peak;
    logic [ADDR_W-1:0]  r_clr_cnt;
    t_req_item          r_req;
    logic [ENTRY_W-1:0] r_rd_data;
    t_rsp_item          r_rsp, n_rsp;

    logic [OFS_W-1:0]   lim;
    logic [15:0]        a_mask;
    logic [SUM_W-1:0]   round_sum;
    logic [SUM_W-1:0]   aligned;
    logic [SUM_W-1:0]   adj;
    logic [END_W-1:0]   alloc_end;
    logic               alloc_ok;
    logic [OFS_W-1:0]   rd_addr_full;
    logic [OFS_W-1:0]   ent_size;
    logic [ADJ_W-1:0]   ent_adj;
    logic [OFS_W:0]     free_end;
    logic [OFS_W+1:0]   drop;

    logic               mem_we;
    logic [ADDR_W-1:0]  mem_waddr;
    logic [ENTRY_W-1:0] mem_wdata;

    assign lim = (r_arena > OFS_W'(ARENA_BYTES)) ? OFS_W'(ARENA_BYTES) : r_arena;

    // Round the top up to the alignment; the header sits at the aligned position.
    assign a_mask    = (16'(1) << r_req.align_log2) - 16'(1);
    assign round_sum = SUM_W'(r_top) + SUM_W'(a_mask);
    assign aligned   = round_sum & ~SUM_W'(a_mask);
    assign adj       = aligned - SUM_W'(r_top);
    assign alloc_end = END_W'(aligned) + END_W'(HEADER_BYTES) + END_W'(r_req.request_bytes);
    assign alloc_ok  = (alloc_end <= END_W'(lim));

    assign ent_size = r_rd_data[OFS_W-1:0];
    assign ent_adj  = r_rd_data[ENTRY_W-1:OFS_W];
    assign free_end = (OFS_W+1)'(r_req.free_offset) + (OFS_W+1)'(ent_size);
    assign drop     = (OFS_W+2)'(HEADER_BYTES) + (OFS_W+2)'(ent_size) + (OFS_W+2)'(ent_adj);

    always_comb begin
        n_top  = r_top;
        n_peak = r_peak;
        n_rsp  = '0;
        case (t_opcode'(r_req.opcode))
            OP_ALLOC: begin
                if (!alloc_ok) begin
                    n_rsp.status = ST_NO_SPACE;
                end else begin
                    n_top = alloc_end[OFS_W-1:0];
                    if (n_top > r_peak) n_peak = n_top;
                    n_rsp.granted_offset     = OFS_W'(aligned + SUM_W'(HEADER_BYTES));
                    n_rsp.granted_bytes      = r_req.request_bytes;
                    n_rsp.granted_align_log2 = r_req.align_log2;
                end
            end
            OP_FREE: begin
                if (r_req.free_offset == '0) begin
                    n_rsp.status = ST_NULL;
                end else if (r_req.free_offset < OFS_W'(HEADER_BYTES) ||
                             r_req.free_offset > r_top) begin
                    n_rsp.status = ST_BAD_HEADER;
                end else if (free_end != (OFS_W+1)'(r_top)) begin
                    n_rsp.status = ST_NOT_TOP;
                end else if (drop > (OFS_W+2)'(r_top)) begin
                    n_top = '0;
                end else begin
                    n_top = r_top - drop[OFS_W-1:0];
                end
            end
            OP_ROLLBACK: begin
                if (r_req.marker_offset > r_top) begin
                    n_rsp.status = ST_BAD_MARKER;
                end else begin
                    n_top = r_req.marker_offset;
                end
            end
            OP_RESET: begin
                n_top = '0;
            end
            default: n_top = r_top;
        endcase
        n_rsp.used_bytes = n_top;
        n_rsp.peak_bytes = n_peak;
    end

    // Header writes share the single write port with the clearing pass.
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_clr_cnt;
        mem_wdata = '0;
        if (i_cmd.clear) begin
            mem_we = 1'b1;
        end else if (i_cmd.commit && (t_opcode'(r_req.opcode) == OP_ALLOC) && alloc_ok) begin
            mem_we    = 1'b1;
            mem_waddr = aligned[ADDR_W-1:0];
            mem_wdata = {adj[ADJ_W-1:0], r_req.request_bytes};
        end
    end

    assign rd_addr_full = i_req.free_offset - OFS_W'(HEADER_BYTES);

    always_ff @(posedge i_clk) begin
        if (mem_we) mem[mem_waddr] <= mem_wdata;
        if (i_cmd.capture) r_rd_data <= mem[rd_addr_full[ADDR_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) r_req <= i_req;
        if (i_cmd.commit)  r_rsp <= n_rsp;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_arena   <= OFS_W'(ARENA_BYTES);
            r_top     <= '0;
            r_peak    <= '0;
            r_clr_cnt <= '0;
        end else begin
            if (i_cfg_we) r_arena <= i_cfg_data;
            if (i_cmd.clear) r_clr_cnt <= r_clr_cnt + ADDR_W'(1);
            if (i_cmd.commit) begin
                r_top  <= n_top;
                r_peak <= n_peak;
            end
        end
    end

    assign o_sts.clr_done = i_cmd.clear && (r_clr_cnt == '1);
    assign o_rsp          = r_rsp;

endmodule

### design/sawh_checker.sv
module sawh_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_rsp_valid,
    input logic                 i_rsp_ready,
    input sawh_pkg::t_rsp_item  i_rsp
);
    import sawh_pkg::*;

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> (i_rsp.status <= ST_BAD_MARKER))
        else $error("status code out of range");

    // A failed transaction grants nothing (a successful non-allocate one is not checked).
    a_fail_grants_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && (i_rsp.status != ST_OK)) |->
            (i_rsp.granted_offset == '0 && i_rsp.granted_bytes == '0 &&
             i_rsp.granted_align_log2 == '0))
        else $error("grant fields set on a failed transaction");

    a_used_below_peak: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> (i_rsp.used_bytes <= i_rsp.peak_bytes))
        else $error("stack top above peak");

    a_grant_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && i_rsp.granted_offset != '0) |->
            ((14'(i_rsp.granted_offset) + 14'(i_rsp.granted_bytes)) ==
             14'(i_rsp.used_bytes)))
        else $error("granted block does not end at the new top");

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_ready) |=> (i_rsp_valid && $stable(i_rsp)))
        else $error("stalled result changed");

endmodule

bind stack_allocator_with_headers sawh_checker u_sawh_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_rsp       (o_rsp.payload)
);
